// ===== rtl/evc_pkg.sv =====
// Package with shared types and constants for the eigenvector check block.
`default_nettype none
package evc_pkg;
    localparam int unsigned MAX_DIM_DEF = 8;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned CFG_W = 16;
    localparam logic [3:0] DIM_RESET = 4'd8;
    localparam logic [15:0] TOL_RESET = 16'd1;
    localparam logic CFG_DIM = 1'b0;
    localparam logic CFG_TOL = 1'b1;
    localparam logic MODE_MATRIX = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    typedef struct packed {
        logic clr_acc;
        logic mac;
        logic fin_row;
        logic div_start;
        logic chk;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic vi_zero;
        logic agree;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/eigenvector_check_top.sv =====
// Top level of the eigenvector check block.
// Matrix and vector elements are written one item per cycle while o_stall is
// low. The vector item marked last starts the check: each of the dim rows
// streams its products through one 32x32 multiplier, then runs the
// one-bit-per-cycle ratio divider when that row's vector element is
// nonzero; the dim result items then leave in index order, held while i_stall is high.
// No input item is taken until the last result item has been delivered.
// Stores are not cleared at reset and must be written before use.
`default_nettype none
module eigenvector_check_top #(
    parameter int unsigned MAX_DIM = evc_pkg::MAX_DIM_DEF,
    localparam int unsigned AW = $clog2(MAX_DIM)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_mode,
    input  wire logic [2:0]         i_row_index,
    input  wire logic [2:0]         i_col_index,
    input  wire logic signed [31:0] i_element_value,
    input  wire logic               i_last_element,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_out_index,
    output logic signed [31:0]      o_out_value,
    output logic                    o_is_eigenvector,
    output logic                    o_last_result,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    logic [3:0] r_dim;
    logic [15:0] r_tol;
    logic w_busy, w_acc, w_first;
    logic [AW-1:0] w_ri, w_rj;
    evc_pkg::t_cmd w_cmd;
    evc_pkg::t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= evc_pkg::DIM_RESET;
            r_tol <= evc_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                evc_pkg::CFG_DIM: r_dim <= i_cfg_data[3:0];
                evc_pkg::CFG_TOL: r_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = w_busy;
    assign w_acc = i_valid && !w_busy;

    logic w_ok_r, w_ok_c;
    assign w_ok_r = (32'(i_row_index) < MAX_DIM);
    assign w_ok_c = (32'(i_col_index) < MAX_DIM);

    evc_dp #(.MAX_DIM(MAX_DIM)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_mw(w_acc && (i_mode == evc_pkg::MODE_MATRIX) && w_ok_r && w_ok_c),
        .i_vw(w_acc && (i_mode == evc_pkg::MODE_VECTOR) && w_ok_r),
        .i_row(i_row_index), .i_col(i_col_index), .i_val(i_element_value),
        .i_ri(w_ri), .i_rj(w_rj), .i_tol(r_tol), .i_cmd(w_cmd),
        .i_first(w_first), .o_stat(w_stat), .o_vout(o_out_value));

    evc_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_go(w_acc && (i_mode == evc_pkg::MODE_VECTOR) && i_last_element),
        .i_dim(r_dim),
        .i_stat(w_stat), .i_ostall(i_stall), .o_busy(w_busy),
        .o_ri(w_ri), .o_rj(w_rj), .o_cmd(w_cmd), .o_first(w_first),
        .o_valid(o_valid), .o_idx(o_out_index), .o_last(o_last_result),
        .o_is_eig(o_is_eigenvector));
endmodule
`default_nettype wire

// ===== rtl/evc_ram.sv =====
// Generic single-port-write RAM with registered read.
`default_nettype none
module evc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/evc_div.sv =====
// Radix-2 restoring divider for the ratio, signed, truncating, saturated.
`default_nettype none
module evc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);
    // Numerator is num*65536, 48 bits magnitude; one quotient bit per cycle.
    logic [47:0] r_n, n_n;
    logic [31:0] r_d;
    logic [48:0] r_rem, n_rem;
    logic [47:0] r_q, n_q;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg, r_done;
    logic [48:0] w_try;
    logic [48:0] w_sh;
    logic [31:0] w_an, w_ad;

    assign w_an = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign w_ad = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign w_sh = {r_rem[47:0], r_n[47]};
    assign w_try = w_sh - {17'd0, r_d};

    always_comb begin
        n_n = {r_n[46:0], 1'b0};
        if (!w_try[48]) begin
            n_rem = w_try;
            n_q = {r_q[46:0], 1'b1};
        end else begin
            n_rem = w_sh;
            n_q = {r_q[46:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd47;
                r_n <= {w_an, 16'd0};
                r_d <= w_ad;
                r_rem <= '0;
                r_q <= '0;
                r_neg <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                r_n <= n_n;
                r_rem <= n_rem;
                r_q <= n_q;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_comb begin
        if (r_neg) o_quo = (r_q > 48'h80000000) ? 32'sh80000000 : 32'(-r_q);
        else o_quo = (r_q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(r_q);
    end
    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== rtl/evc_dp.sv =====
// Datapath: stores, multiply-accumulate, ratio check and output register.
`default_nettype none
module evc_dp #(
    parameter int unsigned MAX_DIM = evc_pkg::MAX_DIM_DEF,
    localparam int unsigned AW = $clog2(MAX_DIM)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_mw,
    input  wire logic                i_vw,
    input  wire logic [2:0]          i_row,
    input  wire logic [2:0]          i_col,
    input  wire logic signed [31:0]  i_val,
    input  wire logic [AW-1:0]       i_ri,
    input  wire logic [AW-1:0]       i_rj,
    input  wire logic [15:0]         i_tol,
    input  wire evc_pkg::t_cmd       i_cmd,
    input  wire logic                i_first,
    output evc_pkg::t_stat           o_stat,
    output logic signed [31:0]       o_vout
);
    logic [31:0] w_m, w_v, w_vi;
    logic signed [31:0] r_m, r_v;
    logic signed [63:0] r_p;
    logic signed [69:0] r_acc;
    logic signed [31:0] r_y, r_vi, r_ref, w_q;
    logic r_agree, r_have, w_ddone;
    logic signed [69:0] w_fl;
    logic signed [32:0] w_diff, w_ad;

    // The matrix is addressed by {row, column}, so its depth is a power of two.
    evc_ram #(.WIDTH(32), .DEPTH(2 ** (2 * AW))) u_m (
        .i_clk(i_clk), .i_we(i_mw),
        .i_waddr({AW'(i_row), AW'(i_col)}), .i_wdata(i_val),
        .i_raddr({i_ri, i_rj}), .o_rdata(w_m));
    evc_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_v (
        .i_clk(i_clk), .i_we(i_vw), .i_waddr(AW'(i_row)), .i_wdata(i_val),
        .i_raddr(i_rj), .o_rdata(w_v));
    evc_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_vi (
        .i_clk(i_clk), .i_we(i_vw), .i_waddr(AW'(i_row)), .i_wdata(i_val),
        .i_raddr(i_ri), .o_rdata(w_vi));

    // The exact 70-bit sum is floored by an arithmetic right shift of 16.
    assign w_fl = r_acc >>> 16;

    evc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_y), .i_den(r_vi), .o_done(w_ddone), .o_quo(w_q));

    assign w_diff = 33'(w_q) - 33'(r_ref);
    assign w_ad = w_diff[32] ? -w_diff : w_diff;

    always_ff @(posedge i_clk) begin
        r_m <= w_m;
        r_v <= w_v;
        r_p <= r_m * r_v;
        if (i_cmd.clr_acc) r_acc <= '0;
        else if (i_cmd.mac) r_acc <= r_acc + 70'(r_p);
        if (i_cmd.fin_row) begin
            r_vi <= w_vi;
            if (w_fl > 70'sd2147483647) r_y <= 32'sh7FFFFFFF;
            else if (w_fl < -70'sd2147483648) r_y <= 32'sh80000000;
            else r_y <= 32'(w_fl);
        end
        if (i_cmd.emit) o_vout <= r_agree ? w_v : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agree <= 1'b1;
            r_have <= 1'b0;
        end else if (i_first) begin
            r_agree <= 1'b1;
            r_have <= 1'b0;
        end else if (i_cmd.chk) begin
            if (!r_have) begin
                r_ref <= w_q;
                r_have <= 1'b1;
            end else if (w_ad > 33'(i_tol)) r_agree <= 1'b0;
        end
    end

    assign o_stat.div_done = w_ddone;
    assign o_stat.vi_zero = (r_vi == 32'sd0);
    assign o_stat.agree = r_agree;
endmodule
`default_nettype wire

// ===== rtl/evc_ctrl.sv =====
// Controller: sequences row products, divisions and result emission.
`default_nettype none
module evc_ctrl #(
    parameter int unsigned MAX_DIM = evc_pkg::MAX_DIM_DEF,
    localparam int unsigned AW = $clog2(MAX_DIM)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire logic [3:0]    i_dim,
    input  wire evc_pkg::t_stat i_stat,
    input  wire logic          i_ostall,
    output logic               o_busy,
    output logic [AW-1:0]      o_ri,
    output logic [AW-1:0]      o_rj,
    output evc_pkg::t_cmd      o_cmd,
    output logic               o_first,
    output logic               o_valid,
    output logic [2:0]         o_idx,
    output logic               o_last,
    output logic               o_is_eig
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MAC = 7'b0000010, S_FIN = 7'b0000100,
        S_DIV = 7'b0001000, S_WAIT = 7'b0010000, S_RD = 7'b0100000,
        S_OUT = 7'b1000000
    } t_state;
    localparam int unsigned CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

    t_state r_st, n_st;
    logic [AW:0] r_i, n_i;
    logic [AW+1:0] r_j, n_j;
    logic [AW:0] w_dm1;
    logic [2:0] r_drain, n_drain;
    logic [3:0] w_dim;
    logic r_ov, n_ov, r_ol;

    always_comb begin
        w_dim = i_dim;
        if (w_dim == 4'd0) w_dim = 4'd1;
        if (w_dim > 4'(CAP)) w_dim = 4'(CAP);
    end
    assign w_dm1 = (AW+1)'(w_dim - 4'd1);

    always_comb begin
        n_st = r_st; n_i = r_i; n_j = r_j; n_drain = r_drain; n_ov = r_ov;
        o_cmd = '0;
        o_first = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_go) begin
                n_st = S_MAC; n_i = '0; n_j = '0; n_drain = '0;
                o_first = 1'b1; o_cmd.clr_acc = 1'b1;
            end
            S_MAC: begin
                // Read addresses advance; each product lands after the RAM read, r_m/r_v and r_p registers.
                if (r_drain >= 3'd3) o_cmd.mac = 1'b1;
                n_j = r_j + 1'b1;
                n_drain = (r_drain == 3'd3) ? 3'd3 : r_drain + 3'd1;
                if (r_j == (AW+2)'(w_dim + 4'd2)) n_st = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_row = 1'b1;
                n_st = S_DIV;
            end
            S_DIV: begin
                if (i_stat.vi_zero) begin
                    n_st = (r_i == w_dm1) ? S_RD : S_MAC;
                    n_i = r_i + 1'b1; n_j = '0; n_drain = '0;
                    o_cmd.clr_acc = 1'b1;
                    if (r_i == w_dm1) begin n_i = '0; end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_st = S_WAIT;
                end
            end
            S_WAIT: if (i_stat.div_done) begin
                o_cmd.chk = 1'b1;
                n_i = r_i + 1'b1; n_j = '0; n_drain = '0;
                o_cmd.clr_acc = 1'b1;
                n_st = (r_i == w_dm1) ? S_RD : S_MAC;
                if (r_i == w_dm1) n_i = '0;
            end
            S_RD: begin
                // Vector read address is set; data arrives next cycle.
                if (!r_ov || !i_ostall) begin
                    n_st = S_OUT;
                    n_ov = 1'b0;
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_ov = 1'b1;
                if (r_i == w_dm1) n_st = S_IDLE;
                else begin n_i = r_i + 1'b1; n_st = S_RD; end
            end
            default: n_st = S_IDLE;
        endcase
        if (r_ov && !i_ostall && r_st != S_RD && r_st != S_OUT) n_ov = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_i <= '0; r_j <= '0; r_drain <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_i <= n_i; r_j <= n_j; r_drain <= n_drain; r_ov <= n_ov;
        end
        if (r_st == S_OUT) begin
            o_idx <= 3'(r_i);
            r_ol <= (r_i == w_dm1);
            o_is_eig <= i_stat.agree;
        end
    end

    assign o_ri = r_i[AW-1:0];
    assign o_rj = (r_st == S_RD || r_st == S_OUT) ? r_i[AW-1:0] : r_j[AW-1:0];
    assign o_valid = r_ov;
    assign o_last = r_ol;
    assign o_busy = (r_st != S_IDLE) || r_ov;
endmodule
`default_nettype wire
